FILE: rtl/mkbs_pkg.sv
// Shared types and constants of the masked-key binary search block.
`default_nettype none
package mkbs_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PosW     = 12;
  localparam int unsigned CountW   = 13;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 48;

  localparam logic [ValueW-1:0] ValueAllOnes = '1;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ID_MASK     = 8'd0,
    CFG_COUNT_BANK0 = 8'd1,
    CFG_COUNT_BANK1 = 8'd2,
    CFG_REJECT      = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } mkbs_entry_t;

endpackage
`default_nettype wire

FILE: rtl/mkbs_ram.sv
// Simple dual-port table memory holding one key and value per entry.
`default_nettype none
module mkbs_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire mkbs_pkg::mkbs_entry_t wr_entry_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output      mkbs_pkg::mkbs_entry_t rd_entry_o
);
  import mkbs_pkg::*;

  mkbs_entry_t mem [Depth];
  mkbs_entry_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    rd_entry_q <= mem[rd_addr_i];
  end

  assign rd_entry_o = rd_entry_q;

endmodule
`default_nettype wire

FILE: rtl/masked_key_binary_search.sv
// Top level of the masked-key binary search engine over two sorted table banks.
//
// Input items arrive on the s_axis channel. A load item (tuser kind 0) writes a key and a
// value to one position of one bank in the cycle of its transfer and causes no result.
// A search item (tuser kind 1) masks its key with id_mask and bisects the first count
// entries of the chosen bank; it yields one result on the m_axis channel: found in tuser,
// the match position and the stored value in tdata.
// Each bisection step has a read state, which addresses the table memory through its one
// read port, and a compare state; the idle state takes a search in and the done state
// hands its result to the output register. s_axis_tready is low while a search runs.
// The next item is taken in the cycle after the result is loaded; a load leaves the block
// idle, so a further item can follow it at once. Registers are written over the cfg
// channel, which is always ready; the user must write them only while the block is idle,
// and the block itself does not enforce it. A finished result sits in an output register;
// while the receiver stalls, loads are still taken, and a further search finishes its
// bisection and then waits for the register. Reset clears the registers to their defaults
// (id_mask all ones, counts zero) and empties the output register. The table memory holds
// no defined content after reset.
`default_nettype none
module masked_key_binary_search #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned BANK_COUNT  = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // position, entry_key, entry_value, search_key from bit 0 up, zero filled
  input  wire logic [mkbs_pkg::InDataW-1:0]   s_axis_tdata,
  // kind, bank from bit 0 up
  input  wire logic [mkbs_pkg::InUserW-1:0]   s_axis_tuser,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // match_position, match_value from bit 0 up, zero filled
  output      logic [mkbs_pkg::OutDataW-1:0]  m_axis_tdata,
  // found
  output      logic                           m_axis_tuser,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [mkbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [mkbs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mkbs_pkg::*;

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned Depth = BANK_COUNT * TABLE_DEPTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] Bank1Base = AddrW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [KeyW-1:0]   id_mask_q;
  logic [CountW-1:0] count0_q;
  logic [CountW-1:0] count1_q;
  logic              reject_q;
  logic [KeyW-1:0]   target_q;
  logic              bank_q;
  logic [CntW-1:0]   lo_q;
  logic [CntW-1:0]   hi_q;
  logic [IdxW-1:0]   mid_q;
  logic              res_found_q;
  logic [PosW-1:0]   res_pos_q;
  logic [ValueW-1:0] res_value_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [PosW-1:0]   out_pos_q;
  logic [ValueW-1:0] out_value_q;

  logic              in_xfer;
  kind_e             in_kind;
  logic              in_bank;
  logic [PosW-1:0]   in_pos;
  logic [KeyW-1:0]   in_entry_key;
  logic [ValueW-1:0] in_entry_value;
  logic [KeyW-1:0]   in_search_key;
  logic              bank_ok;
  logic              pos_ok;
  logic [CountW-1:0] count_sel;
  logic [CntW-1:0]   n_sat;
  logic [IdxW-1:0]   wr_idx;
  logic [AddrW-1:0]  wr_addr;
  logic              wr_en;
  mkbs_entry_t       wr_entry;
  logic [CntW:0]     mid_sum;
  logic [IdxW-1:0]   mid;
  logic [AddrW-1:0]  rd_addr;
  mkbs_entry_t       rd_entry;
  logic [KeyW-1:0]   rd_key_masked;
  logic              value_bad;
  logic              out_free;
  logic              out_load;

  assign in_xfer        = s_axis_tvalid && s_axis_tready;
  assign in_kind        = kind_e'(s_axis_tuser[0]);
  assign in_bank        = s_axis_tuser[1];
  assign in_pos         = s_axis_tdata[11:0];
  assign in_entry_key   = s_axis_tdata[43:12];
  assign in_entry_value = s_axis_tdata[75:44];
  assign in_search_key  = s_axis_tdata[107:76];

  assign bank_ok   = 32'(in_bank) < 32'(BANK_COUNT);
  assign pos_ok    = 32'(in_pos) < 32'(TABLE_DEPTH);
  assign count_sel = in_bank ? count1_q : count0_q;
  assign n_sat     = (32'(count_sel) > 32'(TABLE_DEPTH)) ? CntW'(TABLE_DEPTH) : CntW'(count_sel);

  assign wr_idx   = IdxW'(32'(in_pos));
  assign wr_addr  = in_bank ? (Bank1Base + AddrW'(wr_idx)) : AddrW'(wr_idx);
  assign wr_en    = in_xfer && (in_kind == KIND_LOAD) && bank_ok && pos_ok;
  assign wr_entry = '{key: in_entry_key, value: in_entry_value};

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CntW + 1)'(1);
  assign mid     = mid_sum[IdxW:1];
  assign rd_addr = bank_q ? (Bank1Base + AddrW'(mid)) : AddrW'(mid);

  assign rd_key_masked = rd_entry.key & id_mask_q;
  assign value_bad     = reject_q && ((rd_entry.value == '0) || (rd_entry.value == ValueAllOnes));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_DONE) && out_free;

  mkbs_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_mask_q <= ValueAllOnes;
      count0_q  <= '0;
      count1_q  <= '0;
      reject_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ID_MASK:     id_mask_q <= cfg_data_i;
        CFG_COUNT_BANK0: count0_q  <= cfg_data_i[CountW-1:0];
        CFG_COUNT_BANK1: count1_q  <= cfg_data_i[CountW-1:0];
        CFG_REJECT:      reject_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      bank_q      <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      res_value_q <= '0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_pos_q   <= '0;
      out_value_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_found_q <= res_found_q;
        out_pos_q   <= res_pos_q;
        out_value_q <= res_value_q;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_kind == KIND_SEARCH)) begin
            target_q <= in_search_key & id_mask_q;
            bank_q   <= in_bank;
            lo_q     <= '0;
            hi_q     <= bank_ok ? n_sat : '0;
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= ST_CMP;
          end else begin
            res_found_q <= 1'b0;
            res_pos_q   <= '0;
            res_value_q <= ValueAllOnes;
            state_q     <= ST_DONE;
          end
        end
        ST_CMP: begin
          if (rd_key_masked == target_q) begin
            res_found_q <= !value_bad;
            res_pos_q   <= value_bad ? '0 : PosW'(32'(mid_q));
            res_value_q <= value_bad ? ValueAllOnes : rd_entry.value;
            state_q     <= ST_DONE;
          end else if (rd_key_masked < target_q) begin
            lo_q    <= CntW'(mid_q) + CntW'(1);
            state_q <= ST_READ;
          end else begin
            hi_q    <= CntW'(mid_q);
            state_q <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {4'b0000, out_value_q, out_pos_q};
  assign cfg_ready_o   = 1'b1;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input side ready during a search");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (lo_q <= hi_q))
    else $error("bisection window inverted");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_READ))
    else $error("compare without a preceding memory read");

  a_miss_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> ((out_pos_q == '0) && (out_value_q == ValueAllOnes)))
    else $error("not-found result carries a stale payload");

endmodule
`default_nettype wire

FILE: verif/tb_masked_key_binary_search.sv
// Self-checking testbench of the masked-key binary search engine: table loads and searches.
module tb_masked_key_binary_search;
  timeunit 1ns;
  timeprecision 1ps;

  import mkbs_pkg::*;

  localparam int TableDepth   = 4096;
  localparam int NumPhases    = 10;
  localparam int FullPhase    = 2;
  localparam int OpsPerPhase  = 50;
  localparam int FullSearches = 40;
  localparam int MaxReported  = 10;
  localparam int TailCycles   = 40;
  localparam int KeyLsb       = PosW;
  localparam int ValueLsb     = PosW + KeyW;
  localparam int SearchLsb    = PosW + KeyW + ValueW;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxTop    = 8'hFF;
  localparam logic [KeyW-1:0]    FullMask     = 32'hFFFF_FF00;

  typedef struct {
    kind_e             kind;
    logic              bank;
    logic [PosW-1:0]   pos;
    logic [KeyW-1:0]   entry_key;
    logic [ValueW-1:0] entry_value;
    logic [KeyW-1:0]   search_key;
  } table_op_t;

  typedef struct {
    logic              found;
    logic [PosW-1:0]   pos;
    logic [ValueW-1:0] value;
  } lookup_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  wire                 s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic [InUserW-1:0]  s_tuser   = '0;
  wire                 m_tvalid;
  logic                m_tready  = 1'b0;
  wire [OutDataW-1:0]  m_tdata;
  wire                 m_tuser;
  logic                cfg_valid = 1'b0;
  wire                 cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic [KeyW-1:0]   key_mirror   [2][TableDepth];
  logic [ValueW-1:0] value_mirror [2][TableDepth];
  logic [KeyW-1:0]   mask_cfg = ValueAllOnes;
  logic [CountW-1:0] count_cfg [2] = '{'0, '0};
  logic              reject_cfg = 1'b0;

  logic [KeyW-1:0] plan_key [2][TableDepth];
  int unsigned     plan_n [2] = '{0, 0};
  bit              path_done [2][TableDepth];

  lookup_t     expected_lookups [$];
  table_op_t   pending_ops [$];
  int          errors     = 0;
  bit          in_taken   = 1'b0;
  bit          idle_on    = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  masked_key_binary_search #(
    .TABLE_DEPTH(TableDepth),
    .BANK_COUNT (2)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic lookup_t predict_lookup(input logic bnk, input logic [KeyW-1:0] key);
    lookup_t           res;
    int unsigned       lo, hi, mid;
    logic [KeyW-1:0]   target, probe;
    logic [ValueW-1:0] v;
    res.found = 1'b0;
    res.pos   = '0;
    res.value = ValueAllOnes;
    lo = 0;
    hi = (count_cfg[bnk] > TableDepth) ? TableDepth : count_cfg[bnk];
    target = key & mask_cfg;
    while (lo < hi) begin
      mid = (lo + hi - 1) >> 1;
      probe = key_mirror[bnk][mid] & mask_cfg;
      if (probe == target) begin
        v = value_mirror[bnk][mid];
        if (!(reject_cfg && (v == '0 || v == ValueAllOnes))) begin
          res.found = 1'b1;
          res.pos   = mid[PosW-1:0];
          res.value = v;
        end
        return res;
      end else if (probe < target) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what);
    errors++;
    if (errors <= MaxReported) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Input driver: holds each transfer until accepted, with random gaps between items while idle_on is set.
  always @(negedge clk_i) begin
    logic      nxt_valid;
    table_op_t op;
    if (rst_ni) begin
      nxt_valid = s_tvalid && !in_taken;
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          if (idle_on && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 4);
          end else begin
            op = pending_ops.pop_front();
            s_tdata <= InDataW'({op.search_key, op.entry_value, op.entry_key, op.pos});
            s_tuser <= {op.bank, op.kind};
            nxt_valid = 1'b1;
          end
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: mirrors register writes and loads, predicts searches, checks results.
  always @(posedge clk_i) begin
    lookup_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ID_MASK:     mask_cfg = cfg_data;
          CFG_COUNT_BANK0: count_cfg[0] = cfg_data[CountW-1:0];
          CFG_COUNT_BANK1: count_cfg[1] = cfg_data[CountW-1:0];
          CFG_REJECT:      reject_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        if (kind_e'(s_tuser[0]) == KIND_LOAD) begin
          key_mirror[s_tuser[1]][s_tdata[PosW-1:0]]   = s_tdata[KeyLsb +: KeyW];
          value_mirror[s_tuser[1]][s_tdata[PosW-1:0]] = s_tdata[ValueLsb +: ValueW];
        end else begin
          expected_lookups.push_back(predict_lookup(s_tuser[1], s_tdata[SearchLsb +: KeyW]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_lookups.size() == 0) begin
          note_mismatch("result transfer with no search pending");
        end else begin
          want = expected_lookups.pop_front();
          if (m_tuser !== want.found || m_tdata[PosW-1:0] !== want.pos ||
              m_tdata[PosW +: ValueW] !== want.value) begin
            note_mismatch($sformatf(
              "mismatch: expected found=%0d pos=%0d value=%h, got found=%0d pos=%0d value=%h",
              want.found, want.pos, want.value,
              m_tuser, m_tdata[PosW-1:0], m_tdata[PosW +: ValueW]));
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_ops.size() != 0 || s_tvalid || expected_lookups.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_load(input logic bnk, input logic [PosW-1:0] p,
                           input logic [KeyW-1:0] k, input logic [ValueW-1:0] v);
    table_op_t op;
    op.kind        = KIND_LOAD;
    op.bank        = bnk;
    op.pos         = p;
    op.entry_key   = k;
    op.entry_value = v;
    op.search_key  = $urandom;
    pending_ops.push_back(op);
  endtask

  task automatic push_search(input logic bnk, input logic [KeyW-1:0] k);
    table_op_t op;
    op.kind        = KIND_SEARCH;
    op.bank        = bnk;
    op.pos         = PosW'($urandom_range(0, TableDepth - 1));
    op.entry_key   = $urandom;
    op.entry_value = $urandom;
    op.search_key  = k;
    pending_ops.push_back(op);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ValueAllOnes;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_count();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 2);
    end
    return $urandom_range(3, 40);
  endfunction

  // Masked key that a full bank holds at position p; strictly ascending under FullMask.
  function automatic logic [KeyW-1:0] full_key(input int unsigned p);
    return KeyW'((p * 8 + 4) << 8);
  endfunction

  // Loads only the positions that the bisection of a full bank visits for key k, so that a
  // full bank is searched without loading every entry.
  task automatic plan_path(input logic bnk, input logic [KeyW-1:0] k);
    int unsigned     lo, hi, mid;
    logic [KeyW-1:0] probe, target;
    lo     = 0;
    hi     = TableDepth;
    target = k & FullMask;
    while (lo < hi) begin
      mid   = (lo + hi - 1) >> 1;
      probe = full_key(mid);
      if (!path_done[bnk][mid]) begin
        path_done[bnk][mid] = 1'b1;
        push_load(bnk, mid[PosW-1:0], probe | ($urandom & ~FullMask), pick_value());
      end
      if (probe == target) begin
        hi = lo;
      end else if (probe < target) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
  endtask

  // Loads positions 0 to n-1 with keys non-decreasing under the mask; the masked bits come
  // from a non-decreasing counter spread over the mask bits, the other bits are random.
  task automatic plan_sorted_bank(input logic bnk, input int unsigned n,
                                  input logic [KeyW-1:0] m);
    longint unsigned span, u;
    int unsigned     step_max, j;
    logic [KeyW-1:0] k;
    span     = 64'd1 << $countones(m);
    step_max = 32'(span / (n + 1));
    u        = $urandom_range(0, step_max);
    plan_n[bnk] = n;
    for (int i = 0; i < n; i++) begin
      k = $urandom & ~m;
      j = 0;
      for (int b = 0; b < KeyW; b++) begin
        if (m[b]) begin
          k[b] = u[j];
          j++;
        end
      end
      plan_key[bnk][i] = k;
      push_load(bnk, i[PosW-1:0], k, pick_value());
      if ($urandom_range(0, 7) != 0 && u + 1 < span) begin
        u += (step_max == 0) ? 1 : $urandom_range(1, step_max);
      end
    end
  endtask

  initial begin
    logic [KeyW-1:0] m, k;
    int unsigned     cnt [2];
    int unsigned     r, rej, q;
    logic            b;
    repeat (6) @(negedge clk_i);
    rst_ni  = 1'b1;
    idle_on = 1'b1;

    push_search(1'b0, '0);
    push_search(1'b1, ValueAllOnes);
    push_load(1'b0, 12'd0, 32'h0000_0010, 32'h0000_0011);
    push_load(1'b0, 12'd1, 32'h0000_0020, '0);
    push_load(1'b0, 12'd2, 32'h0000_0030, 32'h0000_0033);
    push_load(1'b0, 12'd3, 32'h0000_0030, 32'h0000_0034);
    push_load(1'b0, 12'd4, 32'h0000_0040, ValueAllOnes);
    push_load(1'b0, 12'd5, 32'h0000_0050, 32'h0000_0055);
    push_load(1'b1, 12'd0, '0, 32'h0000_0001);
    push_load(1'b1, 12'd1, 32'h8000_0000, 32'hDEAD_BEEF);
    push_load(1'b1, 12'd2, ValueAllOnes, 32'hFFFF_FFFE);
    push_load(1'b1, 12'hFFF, ValueAllOnes, ValueAllOnes);
    wait_idle();
    write_reg(CFG_COUNT_BANK0, 32'd6);
    write_reg(CFG_COUNT_BANK1, 32'd3);
    write_reg(CfgIdxUnused, '0);
    write_reg(CfgIdxTop, '0);
    push_search(1'b0, 32'h0000_0010);
    push_search(1'b0, 32'h0000_0030);
    push_search(1'b0, 32'h0000_0050);
    push_search(1'b0, 32'h0000_0005);
    push_search(1'b0, 32'h0000_0060);
    push_search(1'b0, 32'h0000_0035);
    push_search(1'b0, 32'h0000_0020);
    push_search(1'b0, 32'h0000_0040);
    push_search(1'b1, '0);
    push_search(1'b1, ValueAllOnes);
    push_search(1'b1, 32'h8000_0000);
    wait_idle();
    write_reg(CFG_REJECT, 32'd1);
    push_search(1'b0, 32'h0000_0020);
    push_search(1'b0, 32'h0000_0040);
    push_search(1'b0, 32'h0000_0050);
    wait_idle();
    write_reg(CFG_ID_MASK, 32'h0000_FFFF);
    push_search(1'b0, 32'hABCD_0030);
    push_search(1'b1, 32'h1234_0000);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      idle_on = (p % 3 != 2) && (p != NumPhases - 1);
      case (p)
        0:         m = ValueAllOnes;
        1:         m = '0;
        FullPhase: m = FullMask;
        3:         m = 32'hFFFF_0000;
        default:   m = ($urandom_range(0, 1) == 0) ? $urandom : ($urandom & $urandom);
      endcase
      if (p == FullPhase) begin
        cnt[0] = TableDepth;
        cnt[1] = 8191;
      end else begin
        cnt[0] = pick_count();
        cnt[1] = pick_count();
      end
      rej = (p < 2) ? p : $urandom_range(0, 1);
      write_reg(CFG_ID_MASK, m);
      write_reg(CFG_COUNT_BANK0, cnt[0]);
      write_reg(CFG_COUNT_BANK1, cnt[1]);
      write_reg(CFG_REJECT, rej);
      if (p == FullPhase) begin
        repeat (FullSearches) begin
          b = 1'($urandom_range(0, 1));
          q = $urandom_range(0, TableDepth - 1);
          case ($urandom_range(0, 3))
            0:       k = full_key(q) | ($urandom & ~FullMask);
            1:       k = (full_key(q) + 32'h0000_0100) | ($urandom & ~FullMask);
            2:       k = '0;
            default: k = ValueAllOnes;
          endcase
          plan_path(b, k);
          push_search(b, k);
        end
      end else begin
        plan_sorted_bank(1'b0, (cnt[0] > TableDepth) ? TableDepth : cnt[0], m);
        plan_sorted_bank(1'b1, (cnt[1] > TableDepth) ? TableDepth : cnt[1], m);
        repeat (OpsPerPhase) begin
          r = $urandom_range(0, 19);
          b = 1'($urandom_range(0, 1));
          if (r < 2) begin
            push_load(b, PosW'($urandom_range(0, TableDepth - 1)), $urandom, pick_value());
          end else begin
            if (r < 13 && plan_n[b] > 0) begin
              k = (plan_key[b][$urandom_range(0, plan_n[b] - 1)] & m) | ($urandom & ~m);
            end else if (r == 13) begin
              k = '0;
            end else if (r == 14) begin
              k = ValueAllOnes;
            end else begin
              k = $urandom;
            end
            push_search(b, k);
          end
        end
      end
      wait_idle();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (expected_lookups.size() != 0) begin
      note_mismatch("searches left without a result");
    end
    if (errors == 0) begin
      $display("tb_masked_key_binary_search: clean");
    end else begin
      $display("tb_masked_key_binary_search: errors");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb_masked_key_binary_search: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mkbs_pkg.sv
rtl/mkbs_ram.sv
rtl/masked_key_binary_search.sv
verif/tb_masked_key_binary_search.sv
